FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; take in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under an active-low asynchronous reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication under an active-low asynchronous reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hw/rtl/mljs_pkg.sv
// Types and constants for the multicast loss and jitter statistics block.
// Used by the top level, the divider and the port checker.
package mljs_pkg;

	localparam int SEQ_W   = 32;
	localparam int TS_W    = 48;
	localparam int DLY_W   = 32;
	localparam int JIT_W   = 36;
	localparam int LOSS_W  = 32;
	localparam int RATIO_W = 31;

	localparam int S_TDATA_W = 128;
	localparam int M_TDATA_W = 216;

	// output field offsets in m_tdata
	localparam int O_DLY  = 0;
	localparam int O_JIT  = O_DLY + DLY_W;
	localparam int O_LOSS = O_JIT + JIT_W;
	localparam int O_REO  = O_LOSS + LOSS_W;
	localparam int O_DUP  = O_REO + RATIO_W;
	localparam int O_LAST = O_DUP + RATIO_W;
	localparam int O_END  = O_LAST + TS_W;

	localparam int DIV_NUM_W = 48;
	localparam int DIV_DEN_W = 32;
	localparam int DIV_CNT_W = 6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_CHECK,
		ST_SCAN,
		ST_UPDATE,
		ST_CLOSE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		DIV_DELAY,
		DIV_LOSS,
		DIV_REORDER,
		DIV_DUP
	} div_op_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
	} div_rsp_t;

endpackage

FILE: hw/rtl/mljs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mljs_ram #(
	parameter int W  = 32,
	parameter int D  = 41,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/mljs_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mljs_pkg for widths and the request and response structs.
module mljs_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mljs_pkg::div_req_t req,
	output mljs_pkg::div_rsp_t rsp
);

	logic                           busy_q;
	logic                           done_q;
	logic [mljs_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [mljs_pkg::DIV_DEN_W-1:0] rem_q;
	logic [mljs_pkg::DIV_NUM_W-1:0] quo_q;
	logic [mljs_pkg::DIV_DEN_W-1:0] den_q;
	logic [mljs_pkg::DIV_DEN_W:0]   shifted;
	logic                           take;

	assign shifted = {rem_q, quo_q[mljs_pkg::DIV_NUM_W-1]};
	assign take    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == mljs_pkg::DIV_CNT_W'(mljs_pkg::DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= take ? mljs_pkg::DIV_DEN_W'(shifted - {1'b0, den_q})
			              : shifted[mljs_pkg::DIV_DEN_W-1:0];
			quo_q <= {quo_q[mljs_pkg::DIV_NUM_W-2:0], take};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

FILE: hw/rtl/multicast_loss_jitter_stats.sv
// Loss, reorder, duplicate, delay and jitter statistics for one probe source.
// A window report follows the closing transaction once its item steps, the seen-store scan
//   and four divisions in turn on one shared divider are done.
// Transactions are taken one at a time, as s_tready is high only in the idle state; a
//   seen-store scan, and a window close with its divisions, hold the input.
// Reset: arst_n clears state and counters at once; the seen store needs no clearing.
module multicast_loss_jitter_stats #(
	parameter int WINDOW    = 40,
	parameter int STALE_GAP = 150
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// seq_num[31:0], sent_ms[79:32], recv_ms[127:80]
	input  logic [mljs_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// avg_delay_q8[31:0], avg_jitter_q4[67:32], loss_ratio_q16[99:68],
	// reorder_ratio_q16[130:100], dup_ratio_q16[161:131], last_sent_ms[209:162], zero
	output logic [mljs_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int DEPTH = WINDOW + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	localparam int SW = mljs_pkg::SEQ_W;
	localparam int TW = mljs_pkg::TS_W;
	localparam int DW = mljs_pkg::DLY_W;
	localparam int JW = mljs_pkg::JIT_W;
	localparam int LW = mljs_pkg::LOSS_W;
	localparam int RW = mljs_pkg::RATIO_W;

	mljs_pkg::state_t  state_q, state_d;
	mljs_pkg::div_op_t op_q;

	// item registers
	logic [SW-1:0] seq_s1;
	logic [TW-1:0] sent_s1;
	logic [TW-1:0] recv_s1;
	logic [DW-1:0] dly_s1;

	// statistics
	logic          started_q;
	logic [SW-1:0] last_seq_q;
	logic [TW-1:0] last_sent_q;
	logic [31:0]   exp_cnt_q;
	logic [CW-1:0] ucnt_q;
	logic [DW-1:0] dly_sum_q;
	logic [DW-1:0] prev_dly_q;
	logic [JW-1:0] jit_q;
	logic [LW-1:0] loss_q;
	logic [31:0]   reo_q;
	logic [31:0]   dup_sum_q;

	// scan
	logic [CW-1:0] scan_idx_q;
	logic          cmp_vld_s1;
	logic          dup_q;

	// division results
	logic [DW-1:0] res_dly_q;
	logic [LW-1:0] res_loss_q;
	logic [RW-1:0] res_reo_q;
	logic [RW-1:0] res_dup_q;

	logic                           m_tvalid_q;
	logic [mljs_pkg::M_TDATA_W-1:0] m_tdata_q;

	// ram and divider connections
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [SW-1:0] ram_rdata;
	mljs_pkg::div_req_t div_req;
	mljs_pkg::div_rsp_t div_rsp;

	// combinational helpers
	logic          neg_dly;
	logic [TW-1:0] diff;
	logic [DW-1:0] dly_sat;
	logic [SW-1:0] eff_last;
	logic          stale;
	logic          too_old;
	logic [SW-1:0] expect_seq;
	logic          below_expect;
	logic          scan_issue;
	logic          scan_hit;
	logic [SW-1:0] gap;
	logic [SW-1:0] gap_m1;
	logic [32:0]   exp_add;
	logic [32:0]   exp_inc;
	logic [33:0]   loss_add;
	logic [33:0]   loss_dec;
	logic [32:0]   dly_add;
	logic [DW-1:0] nj;
	logic [JW+3:0] jit15;
	logic [JW:0]   jit_sum;
	logic [31:0]   loss_mag;
	logic          out_free;
	logic          win_full;

	assign neg_dly      = recv_s1 < sent_s1;
	assign diff         = recv_s1 - sent_s1;
	assign dly_sat      = (|diff[TW-1:DW]) ? '1 : diff[DW-1:0];
	assign eff_last     = started_q ? last_seq_q : seq_s1;
	assign stale        = (seq_s1 < eff_last) && ((eff_last - seq_s1) > SW'(STALE_GAP));
	assign too_old      = (seq_s1 < last_seq_q) && ((last_seq_q - seq_s1) >= exp_cnt_q);
	assign expect_seq   = last_seq_q + 1'b1;
	assign below_expect = seq_s1 < expect_seq;
	assign scan_issue   = scan_idx_q < ucnt_q;
	assign scan_hit     = cmp_vld_s1 && (ram_rdata == seq_s1);
	assign gap          = seq_s1 - last_seq_q;
	assign gap_m1       = gap - 1'b1;
	assign exp_add      = {1'b0, exp_cnt_q} + {1'b0, gap};
	assign exp_inc      = {1'b0, exp_cnt_q} + 33'd1;
	assign loss_add     = {{2{loss_q[LW-1]}}, loss_q} + {2'b00, gap_m1};
	assign loss_dec     = {{2{loss_q[LW-1]}}, loss_q} - 34'd1;
	assign dly_add      = {1'b0, dly_sum_q} + {1'b0, dly_s1};
	assign nj           = (dly_s1 >= prev_dly_q) ? dly_s1 - prev_dly_q : prev_dly_q - dly_s1;
	assign jit15        = {jit_q, 4'b0000} - {4'b0000, jit_q};
	assign jit_sum      = {1'b0, jit15[JW+3:4]} + {{(JW+1-DW){1'b0}}, nj};
	assign loss_mag     = loss_q[LW-1] ? 32'(-loss_q) : loss_q;
	assign out_free     = !m_tvalid_q || m_tready;
	assign win_full     = exp_cnt_q >= 32'(WINDOW);

	mljs_ram #(
		.W  (SW),
		.D  (DEPTH),
		.AW (AW)
	) u_seen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (seq_s1),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mljs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			mljs_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = mljs_pkg::ST_PREP;
			end
			mljs_pkg::ST_PREP: begin
				state_d = neg_dly ? mljs_pkg::ST_IDLE : mljs_pkg::ST_CHECK;
			end
			mljs_pkg::ST_CHECK: begin
				if (too_old) state_d = mljs_pkg::ST_IDLE;
				else if (below_expect) state_d = mljs_pkg::ST_SCAN;
				else state_d = mljs_pkg::ST_UPDATE;
			end
			mljs_pkg::ST_SCAN: begin
				if (scan_hit || (!scan_issue && !cmp_vld_s1)) state_d = mljs_pkg::ST_UPDATE;
			end
			mljs_pkg::ST_UPDATE: begin
				state_d = mljs_pkg::ST_CLOSE;
			end
			mljs_pkg::ST_CLOSE: begin
				state_d = win_full ? mljs_pkg::ST_DIV_GO : mljs_pkg::ST_IDLE;
			end
			mljs_pkg::ST_DIV_GO: begin
				state_d = mljs_pkg::ST_DIV_WAIT;
			end
			mljs_pkg::ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					state_d = (op_q == mljs_pkg::DIV_DUP) ? mljs_pkg::ST_EMIT
					                                     : mljs_pkg::ST_DIV_GO;
				end
			end
			mljs_pkg::ST_EMIT: begin
				if (out_free) state_d = mljs_pkg::ST_IDLE;
			end
			default: state_d = mljs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = 1'b0;
		ram_re        = 1'b0;
		ram_raddr     = scan_idx_q[AW-1:0];
		ram_we        = 1'b0;
		ram_waddr     = ucnt_q[AW-1:0];
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = exp_cnt_q;
		case (op_q)
			mljs_pkg::DIV_DELAY: begin
				div_req.num = {8'd0, dly_sum_q, 8'd0};
				div_req.den = {{(mljs_pkg::DIV_DEN_W-CW){1'b0}}, ucnt_q};
			end
			mljs_pkg::DIV_LOSS:    div_req.num = {loss_mag, 16'd0};
			mljs_pkg::DIV_REORDER: div_req.num = {reo_q, 16'd0};
			mljs_pkg::DIV_DUP:     div_req.num = {dup_sum_q, 16'd0};
			default:               div_req.num = '0;
		endcase
		case (state_q)
			mljs_pkg::ST_IDLE:   s_tready = 1'b1;
			mljs_pkg::ST_SCAN:   ram_re = scan_issue;
			mljs_pkg::ST_UPDATE: ram_we = !dup_q && (ucnt_q < CW'(DEPTH));
			mljs_pkg::ST_DIV_GO: div_req.start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == mljs_pkg::ST_IDLE && s_tvalid) begin
			seq_s1  <= s_tdata[31:0];
			sent_s1 <= s_tdata[79:32];
			recv_s1 <= s_tdata[127:80];
		end
		if (state_q == mljs_pkg::ST_PREP) begin
			dly_s1 <= dly_sat;
		end
		if (state_q == mljs_pkg::ST_DIV_WAIT && div_rsp.done) begin
			case (op_q)
				mljs_pkg::DIV_DELAY: begin
					if (ucnt_q == '0) res_dly_q <= '0;
					else res_dly_q <= (|div_rsp.quo[47:32]) ? '1 : div_rsp.quo[31:0];
				end
				mljs_pkg::DIV_LOSS: begin
					if (loss_q[LW-1]) begin
						res_loss_q <= (div_rsp.quo > 48'h0000_8000_0000) ? 32'h8000_0000
						              : 32'(-div_rsp.quo[31:0]);
					end else begin
						res_loss_q <= (div_rsp.quo > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF
						              : div_rsp.quo[31:0];
					end
				end
				mljs_pkg::DIV_REORDER: begin
					res_reo_q <= (div_rsp.quo > 48'h0000_7FFF_FFFF) ? '1 : div_rsp.quo[30:0];
				end
				mljs_pkg::DIV_DUP: begin
					res_dup_q <= (div_rsp.quo > 48'h0000_7FFF_FFFF) ? '1 : div_rsp.quo[30:0];
				end
				default: ;
			endcase
		end
		if (state_q == mljs_pkg::ST_EMIT && out_free) begin
			m_tdata_q <= {{(mljs_pkg::M_TDATA_W-mljs_pkg::O_END){1'b0}}, last_sent_q,
			              res_dup_q, res_reo_q, res_loss_q, jit_q, res_dly_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mljs_pkg::ST_IDLE;
			op_q        <= mljs_pkg::DIV_DELAY;
			started_q   <= 1'b0;
			last_seq_q  <= '0;
			last_sent_q <= '0;
			exp_cnt_q   <= '0;
			ucnt_q      <= '0;
			dly_sum_q   <= '0;
			prev_dly_q  <= '0;
			jit_q       <= '0;
			loss_q      <= '0;
			reo_q       <= '0;
			dup_sum_q   <= '0;
			scan_idx_q  <= '0;
			cmp_vld_s1  <= 1'b0;
			dup_q       <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mljs_pkg::ST_EMIT && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				mljs_pkg::ST_PREP: begin
					if (!neg_dly) begin
						started_q <= 1'b1;
						if (stale) begin
							last_seq_q  <= seq_s1 - 1'b1;
							last_sent_q <= '0;
							prev_dly_q  <= '0;
							jit_q       <= '0;
							exp_cnt_q   <= '0;
							ucnt_q      <= '0;
							dly_sum_q   <= '0;
							loss_q      <= '0;
							reo_q       <= '0;
							dup_sum_q   <= '0;
						end else if (!started_q) begin
							last_seq_q <= seq_s1;
						end
					end
				end
				mljs_pkg::ST_CHECK: begin
					if (!too_old) last_sent_q <= sent_s1;
					scan_idx_q <= '0;
					cmp_vld_s1 <= 1'b0;
					dup_q      <= 1'b0;
				end
				mljs_pkg::ST_SCAN: begin
					if (scan_issue) scan_idx_q <= scan_idx_q + 1'b1;
					cmp_vld_s1 <= scan_issue;
					if (scan_hit) dup_q <= 1'b1;
				end
				mljs_pkg::ST_UPDATE: begin
					if (dup_q) begin
						if (dup_sum_q != '1) dup_sum_q <= dup_sum_q + 1'b1;
					end else begin
						if (ucnt_q < CW'(DEPTH)) ucnt_q <= ucnt_q + 1'b1;
						dly_sum_q  <= dly_add[32] ? '1 : dly_add[31:0];
						prev_dly_q <= dly_s1;
						jit_q      <= jit_sum[JW] ? '1 : jit_sum[JW-1:0];
						if (seq_s1 == expect_seq) begin
							exp_cnt_q <= exp_inc[32] ? '1 : exp_inc[31:0];
						end else if (seq_s1 > expect_seq) begin
							exp_cnt_q <= exp_add[32] ? '1 : exp_add[31:0];
							if (loss_add[33:31] == 3'b000 || loss_add[33:31] == 3'b111)
								loss_q <= loss_add[31:0];
							else
								loss_q <= loss_add[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
						end else begin
							if (loss_dec[33:31] == 3'b000 || loss_dec[33:31] == 3'b111)
								loss_q <= loss_dec[31:0];
							else
								loss_q <= 32'h8000_0000;
							if (reo_q != '1) reo_q <= reo_q + 1'b1;
						end
						if (expect_seq <= seq_s1) last_seq_q <= seq_s1;
					end
				end
				mljs_pkg::ST_CLOSE: begin
					op_q <= mljs_pkg::DIV_DELAY;
				end
				mljs_pkg::ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						case (op_q)
							mljs_pkg::DIV_DELAY:   op_q <= mljs_pkg::DIV_LOSS;
							mljs_pkg::DIV_LOSS:    op_q <= mljs_pkg::DIV_REORDER;
							mljs_pkg::DIV_REORDER: op_q <= mljs_pkg::DIV_DUP;
							default:               op_q <= mljs_pkg::DIV_DELAY;
						endcase
					end
				end
				mljs_pkg::ST_EMIT: begin
					if (out_free) begin
						exp_cnt_q  <= '0;
						ucnt_q     <= '0;
						dly_sum_q  <= '0;
						loss_q     <= '0;
						reo_q      <= '0;
						dup_sum_q  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: hw/rtl/mljs_checker.sv
// Port-level checker for multicast_loss_jitter_stats, attached by bind.
// Depends on mljs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mljs_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [mljs_pkg::M_TDATA_W-1:0] m_tdata
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`ASSERT_SAME(a_result_after_work, clk, arst_n, $rose(m_tvalid), !$past(s_tready))
	`ASSERT_SAME(a_pad_zero, clk, arst_n, m_tvalid,
		m_tdata[mljs_pkg::M_TDATA_W-1:mljs_pkg::O_END] == '0)

endmodule

bind multicast_loss_jitter_stats mljs_checker u_mljs_checker (.*);
